// ===== rtl/bcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpe_pkg - shared types and constants for the Bezier point evaluator
// Widths, formats, the binomial table and the word structs used by the stages.
// ----------------------------------------------------------------------------
package bcpe_pkg;

	localparam int MAX_POINTS  = 8;
	localparam int COORD_BITS  = 24;
	localparam int T_FRAC_BITS = 16;
	localparam int WF          = 28;                // weight fraction bits
	localparam int IDX_W       = 3;
	localparam int CNT_W       = 4;
	localparam int T_W         = T_FRAC_BITS + 1;
	localparam int PW          = WF + 1;            // power / product width, <= 1.0
	localparam int WW          = WF + 2;            // weight width, headroom for rounding
	localparam int MW          = COORD_BITS + WW + 1;
	localparam int AW          = MW + 3;            // sum of eight products
	localparam int NPS         = MAX_POINTS - 1;    // power stages

	localparam logic [T_W-1:0]   T_ONE      = T_W'(1) << T_FRAC_BITS;
	localparam logic [PW-1:0]    P_ONE      = PW'(1) << WF;
	localparam logic [WW-1:0]    W_ONE      = WW'(1) << WF;
	localparam logic [CNT_W-1:0] CNT_RESET  = CNT_W'(4);
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_POINTS);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] deg;
		logic             t_lo;   // t = 0, result is slot 0
		logic             t_hi;   // t = 1, result is slot deg
	} item_ctl_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} point_t;

	// C(n, r); zero where r > n
	function automatic logic [5:0] binom(input logic [IDX_W-1:0] n, input logic [IDX_W-1:0] r);
		logic [5:0] row [MAX_POINTS];
		row = '{default: 6'd0};
		case (n)
			3'd0: row = '{6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
			3'd1: row = '{6'd1, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
			3'd2: row = '{6'd1, 6'd2, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};
			3'd3: row = '{6'd1, 6'd3, 6'd3, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0};
			3'd4: row = '{6'd1, 6'd4, 6'd6, 6'd4, 6'd1, 6'd0, 6'd0, 6'd0};
			3'd5: row = '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5, 6'd1, 6'd0, 6'd0};
			3'd6: row = '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6, 6'd1, 6'd0};
			3'd7: row = '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1};
			default: row = '{default: 6'd0};
		endcase
		return row[r];
	endfunction

endpackage

// ===== rtl/bcpe_pow.sv =====
// ----------------------------------------------------------------------------
// bcpe_pow - power chain
// Builds t^k and (1-t)^k in Q.28, one rounded multiply per stage after the first.
// ----------------------------------------------------------------------------
module bcpe_pow (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  bcpe_pkg::item_ctl_t          ctl_in,
	input  bcpe_pkg::point_t             pt_in,
	input  logic [15:0]                  a_in,
	input  logic [15:0]                  b_in,
	output logic                         vld_out,
	output bcpe_pkg::item_ctl_t          ctl_out,
	output bcpe_pkg::point_t             pt_out,
	output logic [bcpe_pkg::PW-1:0]      pa_out [bcpe_pkg::MAX_POINTS],
	output logic [bcpe_pkg::PW-1:0]      pb_out [bcpe_pkg::MAX_POINTS]
);
	import bcpe_pkg::*;

	logic            vld_s [NPS];
	item_ctl_t       ctl_s [NPS];
	point_t          pt_s  [NPS];
	logic [15:0]     a_s   [NPS];
	logic [15:0]     b_s   [NPS];
	logic [PW-1:0]   pa_s  [NPS][NPS];   // [stage][power-1]
	logic [PW-1:0]   pb_s  [NPS][NPS];

	// (p * x + half) >> 16
	function automatic logic [PW-1:0] rmul(input logic [PW-1:0] p, input logic [15:0] x);
		logic [PW+15:0] prod;
		prod = p * x + (PW+16)'(1 << (T_FRAC_BITS - 1));
		return prod[PW+15:T_FRAC_BITS];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NPS; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
			for (int j = 1; j < NPS; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0] <= ctl_in;
			pt_s[0]  <= pt_in;
			a_s[0]   <= a_in;
			b_s[0]   <= b_in;
			for (int k = 0; k < NPS; k++) begin
				pa_s[0][k] <= PW'({a_in, 12'b0});
				pb_s[0][k] <= PW'({b_in, 12'b0});
			end
			for (int j = 1; j < NPS; j++) begin
				ctl_s[j] <= ctl_s[j-1];
				pt_s[j]  <= pt_s[j-1];
				a_s[j]   <= a_s[j-1];
				b_s[j]   <= b_s[j-1];
				for (int k = 0; k < NPS; k++) begin
					if (k == j) begin
						pa_s[j][k] <= rmul(pa_s[j-1][j-1], a_s[j-1]);
						pb_s[j][k] <= rmul(pb_s[j-1][j-1], b_s[j-1]);
					end else begin
						pa_s[j][k] <= pa_s[j-1][k];
						pb_s[j][k] <= pb_s[j-1][k];
					end
				end
			end
		end
	end

	assign vld_out = vld_s[NPS-1];
	assign ctl_out = ctl_s[NPS-1];
	assign pt_out  = pt_s[NPS-1];

	always_comb begin
		pa_out[0] = P_ONE;
		pb_out[0] = P_ONE;
		for (int k = 1; k < MAX_POINTS; k++) begin
			pa_out[k] = pa_s[NPS-1][k-1];
			pb_out[k] = pb_s[NPS-1][k-1];
		end
	end

endmodule

// ===== rtl/bcpe_wgt.sv =====
// ----------------------------------------------------------------------------
// bcpe_wgt - Bernstein weights and control point store
// Pairs the powers, scales by the binomial, and reads or writes the store.
// ----------------------------------------------------------------------------
module bcpe_wgt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_in,
	input  bcpe_pkg::item_ctl_t          ctl_in,
	input  bcpe_pkg::point_t             pt_in,
	input  logic [bcpe_pkg::PW-1:0]      pa_in [bcpe_pkg::MAX_POINTS],
	input  logic [bcpe_pkg::PW-1:0]      pb_in [bcpe_pkg::MAX_POINTS],
	output logic                         vld_out,
	output logic [bcpe_pkg::WW-1:0]      w_out [bcpe_pkg::MAX_POINTS],
	output bcpe_pkg::point_t             pt_out [bcpe_pkg::MAX_POINTS]
);
	import bcpe_pkg::*;

	logic            vld_s8, vld_s9;
	item_ctl_t       ctl_s8;
	point_t          pt_s8;
	logic [PW-1:0]   prod_s8 [MAX_POINTS];
	logic [WW-1:0]   w_s9    [MAX_POINTS];
	point_t          pts_s9  [MAX_POINTS];
	point_t          store_q [MAX_POINTS];

	function automatic logic [PW-1:0] rpair(input logic [PW-1:0] p, input logic [PW-1:0] q);
		logic [2*PW-1:0] m;
		m = p * q + ((2*PW)'(1) << (WF - 1));
		return m[PW+WF-1:WF];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_in;
			vld_s9 <= vld_s8 && (ctl_s8.func == FUNC_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s8 <= ctl_in;
			pt_s8  <= pt_in;
			for (int r = 0; r < MAX_POINTS; r++)
				prod_s8[r] <= rpair(pa_in[r], pb_in[IDX_W'(ctl_in.deg - IDX_W'(r))]);

			// store access in item order: writes land here, evaluations snapshot here
			if (vld_s8 && ctl_s8.func == FUNC_WRITE)
				store_q[ctl_s8.idx] <= pt_s8;
			for (int r = 0; r < MAX_POINTS; r++) begin
				pts_s9[r] <= store_q[r];
				if (ctl_s8.t_lo)
					w_s9[r] <= (r == 0) ? W_ONE : '0;
				else if (ctl_s8.t_hi)
					w_s9[r] <= (IDX_W'(r) == ctl_s8.deg) ? W_ONE : '0;
				else
					w_s9[r] <= WW'(binom(ctl_s8.deg, IDX_W'(r)) * prod_s8[r]);
			end
		end
	end

	assign vld_out = vld_s9;
	assign w_out   = w_s9;
	assign pt_out  = pts_s9;

endmodule

// ===== rtl/bcpe_mac.sv =====
// ----------------------------------------------------------------------------
// bcpe_mac - weighted sum and output rounding
// Point times weight, two-level adder tree, round to nearest and saturate.
// ----------------------------------------------------------------------------
module bcpe_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic [bcpe_pkg::WW-1:0]             w_in  [bcpe_pkg::MAX_POINTS],
	input  bcpe_pkg::point_t                    pt_in [bcpe_pkg::MAX_POINTS],
	output logic                                vld_out,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] res_x,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] res_y,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] res_z
);
	import bcpe_pkg::*;

	localparam int HALF = MAX_POINTS / 2;

	logic                    vld_s10, vld_s11, vld_s12, vld_s13;
	logic signed [MW-1:0]    mx_s10 [MAX_POINTS], my_s10 [MAX_POINTS], mz_s10 [MAX_POINTS];
	logic signed [AW-1:0]    sx_s11 [HALF], sy_s11 [HALF], sz_s11 [HALF];
	logic signed [AW-1:0]    ax_s12, ay_s12, az_s12;
	logic signed [COORD_BITS-1:0] x_s13, y_s13, z_s13;

	function automatic logic signed [MW-1:0] wmul(input logic signed [COORD_BITS-1:0] c,
			input logic [WW-1:0] w);
		logic signed [WW:0] ws;
		ws = signed'({1'b0, w});
		return MW'(c) * MW'(ws);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] finish(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0] v;
		logic signed [AW-WF-1:0] q;
		v = acc + (AW'(1) << (WF - 1));
		q = (AW-WF)'(v >>> WF);
		if (q > (AW-WF)'((1 << (COORD_BITS - 1)) - 1))
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		else if (q < -(AW-WF)'(1 << (COORD_BITS - 1)))
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			return q[COORD_BITS-1:0];
	endfunction

	function automatic logic signed [AW-1:0] sum4(input logic signed [AW-1:0] s [HALF]);
		logic signed [AW-1:0] t;
		t = '0;
		for (int i = 0; i < HALF; i++) t = t + s[i];
		return t;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_in;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < MAX_POINTS; r++) begin
				mx_s10[r] <= wmul(pt_in[r].x, w_in[r]);
				my_s10[r] <= wmul(pt_in[r].y, w_in[r]);
				mz_s10[r] <= wmul(pt_in[r].z, w_in[r]);
			end
			for (int i = 0; i < HALF; i++) begin
				sx_s11[i] <= AW'(mx_s10[2*i]) + AW'(mx_s10[2*i+1]);
				sy_s11[i] <= AW'(my_s10[2*i]) + AW'(my_s10[2*i+1]);
				sz_s11[i] <= AW'(mz_s10[2*i]) + AW'(mz_s10[2*i+1]);
			end
			ax_s12 <= sum4(sx_s11);
			ay_s12 <= sum4(sy_s11);
			az_s12 <= sum4(sz_s11);
			x_s13  <= finish(ax_s12);
			y_s13  <= finish(ay_s12);
			z_s13  <= finish(az_s12);
		end
	end

	assign vld_out = vld_s13;
	assign res_x   = x_s13;
	assign res_y   = y_s13;
	assign res_z   = z_s13;

endmodule

// ===== rtl/bezier_curve_point_eval.sv =====
// ----------------------------------------------------------------------------
// bezier_curve_point_eval - 3D Bezier curve point evaluator
// Stores up to eight control points and evaluates the curve at t in Bernstein
// form, Q1.16 parameter, rounded and saturated 24-bit results.
// ----------------------------------------------------------------------------
//  channel   handshake                 word
//  in        in_valid / in_ready       func, point_index, point_x/y/z, t_value
//  out       out_valid / out_ready     curve_x, curve_y, curve_z
//  cfg       cfg_wr_en                 cfg_wr_data -> point_count
//
//  One word per cycle unless a result is held. From accept to result a word
//  passes the seven-deep power chain (one rounded multiply per power), power
//  pairing, binomial weight, point product, two adder-tree levels, rounding.
//  Reset clears the valid bits and sets point_count to 4; the point store is
//  not cleared. A held result stalls the whole pipeline and in_ready together.
//  Write words update the store at the weight stage, so they stay ordered
//  with evaluations in flight. Write words give no result.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [bcpe_pkg::IDX_W-1:0]          point_index,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_y,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] point_z,
	input  logic [bcpe_pkg::T_W-1:0]            t_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y,
	output logic signed [bcpe_pkg::COORD_BITS-1:0] curve_z,
	input  logic                                cfg_wr_en,
	input  logic [bcpe_pkg::CNT_W-1:0]          cfg_wr_data
);
	import bcpe_pkg::*;

	logic [CNT_W-1:0] point_count_q;
	logic [CNT_W-1:0] cnt;
	logic [T_W-1:0]   a_clamp, b_full;
	logic             en;
	item_ctl_t        ctl_in;
	point_t           pt_in;

	logic             vld_p;
	item_ctl_t        ctl_p;
	point_t           pt_p;
	logic [PW-1:0]    pa [MAX_POINTS];
	logic [PW-1:0]    pb [MAX_POINTS];

	logic             vld_w;
	logic [WW-1:0]    w  [MAX_POINTS];
	point_t           pts [MAX_POINTS];

	// global advance: everything moves unless a result is held
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			point_count_q <= CNT_RESET;
		else if (cfg_wr_en)
			point_count_q <= cfg_wr_data;
	end

	// point count of zero acts as one, above eight as eight
	always_comb begin
		cnt = point_count_q;
		if (cnt == '0)
			cnt = CNT_W'(1);
		else if (cnt > CNT_MAX)
			cnt = CNT_MAX;
	end

	assign a_clamp = (t_value > T_ONE) ? T_ONE : t_value;
	assign b_full  = T_ONE - a_clamp;

	always_comb begin
		ctl_in.func = func;
		ctl_in.idx  = point_index;
		ctl_in.deg  = IDX_W'(cnt - CNT_W'(1));
		ctl_in.t_lo = (a_clamp == '0);
		ctl_in.t_hi = (a_clamp == T_ONE);
		pt_in.x     = point_x;
		pt_in.y     = point_y;
		pt_in.z     = point_z;
	end

	bcpe_pow u_pow (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.ctl_in  (ctl_in),
		.pt_in   (pt_in),
		.a_in    (a_clamp[15:0]),
		.b_in    (b_full[15:0]),
		.vld_out (vld_p),
		.ctl_out (ctl_p),
		.pt_out  (pt_p),
		.pa_out  (pa),
		.pb_out  (pb)
	);

	bcpe_wgt u_wgt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_p),
		.ctl_in  (ctl_p),
		.pt_in   (pt_p),
		.pa_in   (pa),
		.pb_in   (pb),
		.vld_out (vld_w),
		.w_out   (w),
		.pt_out  (pts)
	);

	bcpe_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_w),
		.w_in    (w),
		.pt_in   (pts),
		.vld_out (out_valid),
		.res_x   (curve_x),
		.res_y   (curve_y),
		.res_z   (curve_z)
	);

endmodule

// ===== rtl/bcpe_chk.sv =====
// ----------------------------------------------------------------------------
// bcpe_chk - port checker for the Bezier point evaluator
// Watches stall behaviour and result stability on the top-level ports.
// ----------------------------------------------------------------------------
module bcpe_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_x,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_y,
	input  logic signed [bcpe_pkg::COORD_BITS-1:0] curve_z
);

	// held result stays, unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(curve_x) && $stable(curve_y)
			&& $stable(curve_z))
		else $error("result word changed while stalled");

	// a held result back-pressures the input
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// nothing held: input must be open
	a_open_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with no result pending");

endmodule

bind bezier_curve_point_eval bcpe_chk u_bcpe_chk (.*);
